>>> rtl/core/ddps_pkg.sv
// constants and tables for the differential-drive pose step pipeline
// no dependencies; imported by diff_drive_pose_step
`timescale 1ns / 1ps

package ddps_pkg;

  // heading scale, q2.13 radians
  localparam int PI_Q13      = 25736;
  localparam int TWO_PI_Q13  = 51472;
  localparam int HALF_PI_Q13 = 12868;

  // cordic start vector, q30, gain already folded in
  localparam int CORDIC_GAIN_Q30 = 652032874;

  // atan(2^-i) in q24 radians
  localparam int ATAN_ENTRIES = 24;
  localparam int ATAN_Q24 [ATAN_ENTRIES] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  localparam int TRIG_ITERATIONS_DEF = 16;

  // heading wrap: shift the sum up by whole turns so it stays non-negative,
  // then strip multiples of two pi by restoring steps of 32, 16 .. 1 turns
  localparam int HEAD_WRAP_TURNS = 21;
  localparam int HEAD_BIAS       = PI_Q13 + HEAD_WRAP_TURNS * TWO_PI_Q13;
  localparam int HEAD_STEPS      = 6;
  localparam int HEAD_ACC_W      = 22;

  // internal widths
  localparam int VEC_W   = 34;   // cordic x and y, q30 with headroom
  localparam int ANG_W   = 28;   // cordic angle, q24
  localparam int TRIG_W  = 17;   // rounded cos and sin, q15
  localparam int SPDT_W  = 33;   // speed times dt, q20
  localparam int PROD_W  = TRIG_W + SPDT_W;
  localparam int POS_W   = 32;
  localparam int SUM_W   = POS_W + 2;

endpackage

>>> rtl/core/diff_drive_pose_step.sv
// differential-drive (unicycle) pose step: one explicit euler step per beat
// depends on ddps_pkg
`timescale 1ns / 1ps

// Each input beat carries a pose (x, y in q15.16 metres, heading in q2.13
// radians), a forward speed (q7.8), a turn rate (q3.12) and a time step
// (unsigned q4.12 seconds); each output beat carries the pose after one
// euler step of the unicycle model: x + cos(h)*v*dt, y + sin(h)*v*dt and
// h + w*dt wrapped into [-pi, pi). Positions saturate at the 32-bit limits
// and position_saturated flags it. The block is fully pipelined and takes
// one beat per clock while the skid below is empty; the pipeline depth is
// set by the rotation-mode cordic, which spends one register stage on each
// iteration. Around it sit an entry stage (heading wrap and the two small
// products), a rounding stage, a multiply stage and the output register.
// A one-beat skid register behind the output lets the pipeline keep
// taking beats after out_ready drops until a beat has to wait in it;
// in_ready is the inverse of the skid's valid register. There is no
// state between beats and nothing to set up.
module diff_drive_pose_step
  import ddps_pkg::*;
#(
  parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_y,
  input  logic signed [15:0] start_heading,
  input  logic signed [15:0] linear_speed,
  input  logic signed [15:0] turn_rate,
  input  logic        [15:0] time_step,
  // output channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] end_x,
  output logic signed [31:0] end_y,
  output logic signed [15:0] end_heading,
  output logic               position_saturated
);

  // number of cordic stages actually built
  localparam int NS = (TRIG_ITERATIONS < ATAN_ENTRIES) ? TRIG_ITERATIONS : ATAN_ENTRIES;
  // valid bits: cordic stages 0..NS, rounding stage, multiply stage
  localparam int RND = NS + 1;
  localparam int MUL = NS + 2;

  localparam logic signed [SUM_W-1:0] POS_MAX = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] POS_MIN = -SUM_W'(64'sd2147483648);

  // whole pipeline moves together; it freezes only while the skid is full
  logic               en;
  logic [MUL:0]       pv;

  // ---------------------------------------------------------------------
  // entry: wrap the start heading, fold it into [-pi/2, pi/2], products
  // ---------------------------------------------------------------------
  logic signed [17:0]        wrap_t;
  logic signed [17:0]        wrap_m;
  logic signed [15:0]        hd_w;
  logic signed [15:0]        fold_h;
  logic                      fold_neg;
  logic signed [SPDT_W-1:0]  rtdt_w;
  logic signed [SPDT_W-1:0]  spdt_w;

  always_comb begin
    wrap_t = 18'(start_heading) + 18'(PI_Q13);
    if (wrap_t < 18'sd0) begin
      wrap_m = wrap_t + 18'(TWO_PI_Q13);
    end else if (wrap_t >= 18'(TWO_PI_Q13)) begin
      wrap_m = wrap_t - 18'(TWO_PI_Q13);
    end else begin
      wrap_m = wrap_t;
    end
    hd_w = 16'(wrap_m - 18'(PI_Q13));
    // beyond a quarter turn: rotate by half a turn and flip the result
    if (hd_w > 16'(HALF_PI_Q13)) begin
      fold_h   = hd_w - 16'(PI_Q13);
      fold_neg = 1'b1;
    end else if (hd_w < -16'(HALF_PI_Q13)) begin
      fold_h   = hd_w + 16'(PI_Q13);
      fold_neg = 1'b1;
    end else begin
      fold_h   = hd_w;
      fold_neg = 1'b0;
    end
    // q3.12 * q4.12 = q24 heading change, q7.8 * q4.12 = q20 distance
    rtdt_w = SPDT_W'(turn_rate) * SPDT_W'($signed({1'b0, time_step}));
    spdt_w = SPDT_W'(linear_speed) * SPDT_W'($signed({1'b0, time_step}));
  end

  // ---------------------------------------------------------------------
  // cordic stage registers, index = iterations done
  // ---------------------------------------------------------------------
  logic signed [VEC_W-1:0]   cx     [NS+1];
  logic signed [VEC_W-1:0]   cy     [NS+1];
  logic signed [ANG_W-1:0]   cz     [NS+1];
  logic                      cneg   [NS+1];
  logic signed [POS_W-1:0]   sx_p   [NS+1];
  logic signed [POS_W-1:0]   sy_p   [NS+1];
  logic signed [SPDT_W-1:0]  spdt_p [NS+1];
  logic [HEAD_ACC_W-1:0]     hacc   [1:NS];
  // heading inputs live only in the first stage
  logic signed [15:0]        hd0;
  logic signed [SPDT_W-1:0]  rtdt0;

  always_ff @(posedge clk) begin
    if (en) begin
      cx[0]     <= VEC_W'(CORDIC_GAIN_Q30);
      cy[0]     <= '0;
      cz[0]     <= ANG_W'(fold_h) <<< 11;
      cneg[0]   <= fold_neg;
      sx_p[0]   <= start_x;
      sy_p[0]   <= start_y;
      spdt_p[0] <= spdt_w;
      hd0       <= hd_w;
      rtdt0     <= rtdt_w;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_iter
    localparam logic signed [ANG_W-1:0] ATAN_I = ANG_W'(ATAN_Q24[i]);

    always_ff @(posedge clk) begin
      if (en) begin
        // rotate towards zero residual angle; shifts floor as the model does
        if (!cz[i][ANG_W-1]) begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - ATAN_I;
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + ATAN_I;
        end
        cneg[i+1]   <= cneg[i];
        sx_p[i+1]   <= sx_p[i];
        sy_p[i+1]   <= sy_p[i];
        spdt_p[i+1] <= spdt_p[i];
      end
    end

    // heading sidecar rides along with the cordic stages
    if (i == 0) begin : g_hsum
      logic signed [HEAD_ACC_W:0] hsum;
      always_comb begin
        hsum = (HEAD_ACC_W + 1)'((rtdt0 + SPDT_W'(1024)) >>> 11)
             + (HEAD_ACC_W + 1)'(hd0) + (HEAD_ACC_W + 1)'(HEAD_BIAS);
      end
      always_ff @(posedge clk) begin
        if (en) begin
          hacc[1] <= hsum[HEAD_ACC_W-1:0];
        end
      end
    end else if (i <= HEAD_STEPS) begin : g_hwrap
      localparam logic [HEAD_ACC_W-1:0] TURNS =
        HEAD_ACC_W'(TWO_PI_Q13 * (1 << (HEAD_STEPS - i)));
      always_ff @(posedge clk) begin
        if (en) begin
          hacc[i+1] <= (hacc[i] >= TURNS) ? hacc[i] - TURNS : hacc[i];
        end
      end
    end else begin : g_hpass
      always_ff @(posedge clk) begin
        if (en) begin
          hacc[i+1] <= hacc[i];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // rounding stage: undo the fold, q30 to q15
  // ---------------------------------------------------------------------
  logic signed [VEC_W-1:0]   xf;
  logic signed [VEC_W-1:0]   yf;
  logic signed [TRIG_W-1:0]  cos_r;
  logic signed [TRIG_W-1:0]  sin_r;
  logic signed [POS_W-1:0]   sx_r;
  logic signed [POS_W-1:0]   sy_r;
  logic signed [SPDT_W-1:0]  spdt_r;
  logic signed [15:0]        head_r;

  always_comb begin
    xf = cneg[NS] ? -cx[NS] : cx[NS];
    yf = cneg[NS] ? -cy[NS] : cy[NS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r  <= TRIG_W'((xf + VEC_W'(16384)) >>> 15);
      sin_r  <= TRIG_W'((yf + VEC_W'(16384)) >>> 15);
      sx_r   <= sx_p[NS];
      sy_r   <= sy_p[NS];
      spdt_r <= spdt_p[NS];
      head_r <= 16'($signed({1'b0, hacc[NS]}) - (HEAD_ACC_W + 1)'(PI_Q13));
    end
  end

  // ---------------------------------------------------------------------
  // multiply stage: q15 trig times q20 distance = q35 displacement
  // ---------------------------------------------------------------------
  logic signed [PROD_W-1:0]  px_m;
  logic signed [PROD_W-1:0]  py_m;
  logic signed [POS_W-1:0]   sx_m;
  logic signed [POS_W-1:0]   sy_m;
  logic signed [15:0]        head_m;

  always_ff @(posedge clk) begin
    if (en) begin
      px_m   <= PROD_W'(cos_r) * PROD_W'(spdt_r);
      py_m   <= PROD_W'(sin_r) * PROD_W'(spdt_r);
      sx_m   <= sx_r;
      sy_m   <= sy_r;
      head_m <= head_r;
    end
  end

  // ---------------------------------------------------------------------
  // final add and saturation, feeds output register or skid
  // ---------------------------------------------------------------------
  logic signed [SUM_W-1:0]   sum_x;
  logic signed [SUM_W-1:0]   sum_y;
  logic signed [POS_W-1:0]   new_x;
  logic signed [POS_W-1:0]   new_y;
  logic                      new_sat;
  logic                      sat_x;
  logic                      sat_y;

  always_comb begin
    sum_x = SUM_W'(sx_m) + SUM_W'((px_m + PROD_W'(262144)) >>> 19);
    sum_y = SUM_W'(sy_m) + SUM_W'((py_m + PROD_W'(262144)) >>> 19);
    sat_x = (sum_x > POS_MAX) || (sum_x < POS_MIN);
    sat_y = (sum_y > POS_MAX) || (sum_y < POS_MIN);
    if (sum_x > POS_MAX) begin
      new_x = POS_MAX[POS_W-1:0];
    end else if (sum_x < POS_MIN) begin
      new_x = POS_MIN[POS_W-1:0];
    end else begin
      new_x = sum_x[POS_W-1:0];
    end
    if (sum_y > POS_MAX) begin
      new_y = POS_MAX[POS_W-1:0];
    end else if (sum_y < POS_MIN) begin
      new_y = POS_MIN[POS_W-1:0];
    end else begin
      new_y = sum_y[POS_W-1:0];
    end
    new_sat = sat_x || sat_y;
  end

  // ---------------------------------------------------------------------
  // output register and one-beat skid
  // ---------------------------------------------------------------------
  logic                      skid_v;
  logic signed [POS_W-1:0]   skid_x;
  logic signed [POS_W-1:0]   skid_y;
  logic signed [15:0]        skid_h;
  logic                      skid_sat;
  logic                      incoming;

  assign en       = !skid_v;
  assign in_ready = en;
  assign incoming = en && pv[MUL];

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
    end else if (en) begin
      pv <= {pv[MUL-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_v) begin
        out_valid <= 1'b1;
        skid_v    <= 1'b0;
      end else begin
        out_valid <= incoming;
      end
    end else if (incoming) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_v) begin
        end_x              <= skid_x;
        end_y              <= skid_y;
        end_heading        <= skid_h;
        position_saturated <= skid_sat;
      end else begin
        end_x              <= new_x;
        end_y              <= new_y;
        end_heading        <= head_m;
        position_saturated <= new_sat;
      end
    end
    if (out_valid && !out_ready && incoming) begin
      skid_x   <= new_x;
      skid_y   <= new_y;
      skid_h   <= head_m;
      skid_sat <= new_sat;
    end
  end

`ifndef SYNTH
  // the skid only ever holds a beat behind a waiting output beat
  a_skid_behind_out : assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_valid)
    else $error("skid holds a beat while the output register is empty");

  // the skid fills only from a stalled output
  a_skid_fill : assert property (@(posedge clk) disable iff (rst)
    $rose(skid_v) |-> $past(out_valid && !out_ready))
    else $error("skid filled without an output stall");

  // wrapped heading stays within [-pi, pi)
  a_heading_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (end_heading >= -16'sd25736) && (end_heading <= 16'sd25735))
    else $error("end heading outside the wrapped range");

  // a saturation flag needs a coordinate pinned at a limit
  a_sat_limit : assert property (@(posedge clk) disable iff (rst)
    (out_valid && position_saturated) |->
      (end_x == 32'sh7fffffff) || (end_x == 32'sh80000000) ||
      (end_y == 32'sh7fffffff) || (end_y == 32'sh80000000))
    else $error("saturation flagged with no coordinate at a limit");
`endif

endmodule

>>> test/diff_drive_pose_step_tb.sv
// self-checking testbench for diff_drive_pose_step: directed table then random beats
// holds its own fixed-point predictor of the euler step; needs only the rtl under test
`timescale 1ns / 1ps

module diff_drive_pose_step_tb;

  // predictor constants, q2.13 heading and q24 cordic angle
  localparam longint HEAD_PI      = 25736;
  localparam longint HEAD_TWO_PI  = 51472;
  localparam longint HEAD_HALF_PI = 12868;
  localparam longint VEC_START    = 652032874;   // q30, gain folded in
  localparam int     ATAN_LEN     = 24;
  localparam int     CORDIC_STEPS = 16;
  localparam longint ATAN_TAB [ATAN_LEN] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  localparam int RANDOM_BEATS = 1030;
  localparam int DRAIN_CYCLES = 64;      // covers the pipeline plus the skid slot
  localparam int STALL_AT     = 300;     // beats in before the long receiver hold-off
  localparam int STALL_LEN    = 200;
  localparam int PAUSE_AT     = 500;     // random beat index where the sender drains
  localparam int CALM_FROM    = 700;     // beats in during which nobody idles
  localparam int CALM_TO      = 900;

  localparam logic signed [31:0] P_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] P_MIN = 32'sh8000_0000;
  localparam logic signed [15:0] S_MAX = 16'sh7FFF;
  localparam logic signed [15:0] S_MIN = 16'sh8000;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [15:0] h;
    logic               sat;
  } pose_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [15:0] h;
    logic signed [15:0] v;
    logic signed [15:0] w;
    logic        [15:0] dt;
    logic               known;   // result typed in below rather than predicted
    pose_t              res;
  } stim_row_t;

  localparam pose_t NO_RES = '{32'sd0, 32'sd0, 16'sd0, 1'b0};

  // directed table: x, y, heading, speed, turn rate, dt, known, result
  localparam int NUM_ROWS = 21;
  localparam stim_row_t DIR_ROWS [NUM_ROWS] = '{
    // zero step leaves the pose alone
    '{32'sd0, 32'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0, 1'b1, '{32'sd0, 32'sd0, 16'sd0, 1'b0}},
    '{P_MAX, P_MIN, 16'sd25735, S_MAX, S_MAX, 16'd0, 1'b1,
      '{P_MAX, P_MIN, 16'sd25735, 1'b0}},
    '{P_MIN, P_MAX, -16'sd25736, S_MIN, S_MIN, 16'd0, 1'b1,
      '{P_MIN, P_MAX, -16'sd25736, 1'b0}},
    // both axes clip high at 45 degrees
    '{P_MAX, P_MAX, 16'sd6434, S_MAX, 16'sd0, 16'hFFFF, 1'b1,
      '{P_MAX, P_MAX, 16'sd6434, 1'b1}},
    // both axes clip low at -135 degrees
    '{P_MIN, P_MIN, -16'sd19302, S_MAX, 16'sd0, 16'hFFFF, 1'b1,
      '{P_MIN, P_MIN, -16'sd19302, 1'b1}},
    // full reverse speed at 45 degrees
    '{P_MIN, P_MIN, 16'sd6434, S_MIN, 16'sd0, 16'hFFFF, 1'b1,
      '{P_MIN, P_MIN, 16'sd6434, 1'b1}},
    // from here on the predictor supplies the result
    '{P_MAX, 32'sd0, 16'sd0, S_MAX, S_MAX, 16'hFFFF, 1'b0, NO_RES},
    '{32'sd0, P_MIN, -16'sd12868, S_MAX, S_MIN, 16'hFFFF, 1'b0, NO_RES},
    // headings outside [-pi, pi) get wrapped on the way in
    '{32'sd100, -32'sd100, S_MAX, 16'sd256, 16'sd0, 16'd4096, 1'b0, NO_RES},
    '{-32'sd100, 32'sd100, S_MIN, 16'sd256, 16'sd0, 16'd4096, 1'b0, NO_RES},
    '{32'sd0, 32'sd0, 16'sd25736, 16'sd256, 16'sd4096, 16'd4096, 1'b0, NO_RES},
    // quadrant fold boundaries
    '{32'sd0, 32'sd0, 16'sd12868, 16'sd256, 16'sd0, 16'd4096, 1'b0, NO_RES},
    '{32'sd0, 32'sd0, 16'sd12869, 16'sd256, 16'sd0, 16'd4096, 1'b0, NO_RES},
    '{32'sd0, 32'sd0, -16'sd12868, 16'sd256, 16'sd0, 16'd4096, 1'b0, NO_RES},
    '{32'sd0, 32'sd0, -16'sd12869, 16'sd256, 16'sd0, 16'd4096, 1'b0, NO_RES},
    // heading runs round many turns, then mixed cases
    '{32'sd0, 32'sd0, 16'sd25000, 16'sd0, S_MAX, 16'hFFFF, 1'b0, NO_RES},
    '{32'sd0, 32'sd0, -16'sd25000, 16'sd0, S_MIN, 16'hFFFF, 1'b0, NO_RES},
    '{32'sd0, 32'sd0, 16'sd12868, S_MIN, 16'sd1, 16'hFFFF, 1'b0, NO_RES},
    '{32'sd0, 32'sd0, 16'sd0, 16'sd256, 16'sd0, 16'd4096, 1'b0, NO_RES},
    '{-32'sd1, -32'sd1, -16'sd1, -16'sd1, -16'sd1, 16'd1, 1'b0, NO_RES},
    '{32'sd65536, -32'sd65536, 16'sd8000, -16'sd300, 16'sd1500, 16'd800, 1'b0, NO_RES}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] start_x = '0;
  logic signed [31:0] start_y = '0;
  logic signed [15:0] start_heading = '0;
  logic signed [15:0] linear_speed = '0;
  logic signed [15:0] turn_rate = '0;
  logic        [15:0] time_step = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;
  logic signed [15:0] end_heading;
  logic               position_saturated;

  pose_t poses_offered[$];   // expectation of the beat on the input bus, oldest first
  pose_t poses_due[$];       // accepted beats still waiting for their result
  int    beats_in = 0;
  int    fails = 0;
  logic  calm;

  // stretch where neither side idles
  assign calm = (beats_in >= CALM_FROM) && (beats_in < CALM_TO);

  diff_drive_pose_step #(
    .TRIG_ITERATIONS(CORDIC_STEPS)
  ) dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .start_x            (start_x),
    .start_y            (start_y),
    .start_heading      (start_heading),
    .linear_speed       (linear_speed),
    .turn_rate          (turn_rate),
    .time_step          (time_step),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .end_x              (end_x),
    .end_y              (end_y),
    .end_heading        (end_heading),
    .position_saturated (position_saturated)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------

  // round half towards +inf while dropping s fraction bits
  function automatic longint round_drop(input longint v, input int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  // wrap into [-pi, pi) with a non-negative modulus
  function automatic longint wrap_head(input longint h);
    longint r;
    r = (h + HEAD_PI) % HEAD_TWO_PI;
    if (r < 0) begin
      r += HEAD_TWO_PI;
    end
    return r - HEAD_PI;
  endfunction

  function automatic longint clip32(input longint v, inout bit clipped);
    if (v > longint'(P_MAX)) begin
      clipped = 1'b1;
      return longint'(P_MAX);
    end
    if (v < longint'(P_MIN)) begin
      clipped = 1'b1;
      return longint'(P_MIN);
    end
    return v;
  endfunction

  function automatic pose_t euler_pose(input stim_row_t r);
    longint hw, hf, sp, rt, dt, vx, vy, z, tx, c, s, nx, ny, nh;
    bit     flip, clipped;
    int     i;
    pose_t  p;
    hw = wrap_head(longint'($signed(r.h)));
    sp = longint'($signed(r.v));
    rt = longint'($signed(r.w));
    dt = longint'(r.dt);
    // fold into [-pi/2, pi/2] and flip the vector afterwards
    hf = hw;
    flip = 1'b0;
    if (hf > HEAD_HALF_PI) begin
      hf -= HEAD_PI;
      flip = 1'b1;
    end else if (hf < -HEAD_HALF_PI) begin
      hf += HEAD_PI;
      flip = 1'b1;
    end
    z = hf * 2048;
    vx = VEC_START;
    vy = 0;
    for (i = 0; i < CORDIC_STEPS && i < ATAN_LEN; i++) begin
      tx = vx;
      if (z >= 0) begin
        vx = vx - (vy >>> i);
        vy = vy + (tx >>> i);
        z -= ATAN_TAB[i];
      end else begin
        vx = vx + (vy >>> i);
        vy = vy - (tx >>> i);
        z += ATAN_TAB[i];
      end
    end
    if (flip) begin
      vx = -vx;
      vy = -vy;
    end
    c = round_drop(vx, 15);
    s = round_drop(vy, 15);
    clipped = 1'b0;
    nx = clip32(longint'($signed(r.x)) + round_drop(c * sp * dt, 19), clipped);
    ny = clip32(longint'($signed(r.y)) + round_drop(s * sp * dt, 19), clipped);
    nh = wrap_head(hw + round_drop(rt * dt, 11));
    p.x = nx[31:0];
    p.y = ny[31:0];
    p.h = nh[15:0];
    p.sat = clipped;
    return p;
  endfunction

  // ---------------------------------------------------------------------
  // random field pickers
  // ---------------------------------------------------------------------

  function automatic logic signed [31:0] pick_pos();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6, 7: return $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
      8:          return P_MAX - $urandom_range(0, 32'h0010_0000);
      default:    return P_MIN + $urandom_range(0, 32'h0010_0000);
    endcase
  endfunction

  function automatic logic signed [15:0] pick_heading();
    logic signed [15:0] edges [8];
    edges = '{16'sd25735, -16'sd25736, 16'sd25736, -16'sd25737,
              16'sd12868, 16'sd12869, -16'sd12868, -16'sd12869};
    case ($urandom_range(9))
      8:       return 16'($urandom);                  // anywhere in 16 bits, wrapped
      9:       return edges[$urandom_range(7)];
      default: return 16'($urandom_range(0, 51471) - 25736);
    endcase
  endfunction

  function automatic logic signed [15:0] pick_rate();
    logic signed [15:0] edges [5];
    edges = '{16'sd0, S_MAX, S_MIN, 16'sd1, -16'sd1};
    case ($urandom_range(9))
      8:       return edges[$urandom_range(4)];
      9:       return 16'($urandom_range(0, 1023) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_dt();
    case ($urandom_range(9))
      7:       return 16'($urandom_range(0, 64));
      8:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      9:       return 16'd4096;
      default: return 16'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------

  // offer one beat and hold it until the block takes it
  task automatic offer(input stim_row_t row);
    while (!calm && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    poses_offered.push_back(row.known ? row.res : euler_pose(row));
    in_valid      <= 1'b1;
    start_x       <= row.x;
    start_y       <= row.y;
    start_heading <= row.h;
    linear_speed  <= row.v;
    turn_rate     <= row.w;
    time_step     <= row.dt;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop offering until every accepted beat has come out again
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (poses_due.size() != 0 || poses_offered.size() != 0);
  endtask

  initial begin : feed
    int        n;
    stim_row_t row;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (n = 0; n < NUM_ROWS; n++) begin
      offer(DIR_ROWS[n]);
    end
    for (n = 0; n < RANDOM_BEATS; n++) begin
      if (n == PAUSE_AT) begin
        hold_until_drained();
      end
      row.x     = pick_pos();
      row.y     = pick_pos();
      row.h     = pick_heading();
      row.v     = pick_rate();
      row.w     = pick_rate();
      row.dt    = pick_dt();
      row.known = 1'b0;
      row.res   = NO_RES;
      offer(row);
    end
    hold_until_drained();
    // anything the block still emits now has no expectation and gets flagged
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("diff_drive_pose_step_tb: clean");
    end else begin
      $display("diff_drive_pose_step_tb: errors");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // receiver side: random idling plus one long hold-off
  // ---------------------------------------------------------------------

  initial begin : drain
    int  stall_left;
    bit  stall_done;
    stall_left = 0;
    stall_done = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (!stall_done && beats_in >= STALL_AT) begin
        // the sender keeps offering, so the pipe fills and in_ready drops
        stall_done = 1'b1;
        stall_left = STALL_LEN - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 9);
      end
    end
  end

  // ---------------------------------------------------------------------
  // beat monitor and checker
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    pose_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        poses_due.push_back(poses_offered.pop_front());
        beats_in <= beats_in + 1;
      end
      if (out_valid && out_ready) begin
        if (poses_due.size() == 0) begin
          $display("%0t: result beat with nothing expected, got x %0d y %0d h %0d sat %0b",
                   $time, end_x, end_y, end_heading, position_saturated);
          fails++;
        end else begin
          want = poses_due.pop_front();
          if (end_x !== want.x) begin
            $display("%0t: end_x expected %0d got %0d", $time, want.x, end_x);
            fails++;
          end
          if (end_y !== want.y) begin
            $display("%0t: end_y expected %0d got %0d", $time, want.y, end_y);
            fails++;
          end
          if (end_heading !== want.h) begin
            $display("%0t: end_heading expected %0d got %0d", $time, want.h, end_heading);
            fails++;
          end
          if (position_saturated !== want.sat) begin
            $display("%0t: position_saturated expected %0b got %0b",
                     $time, want.sat, position_saturated);
            fails++;
          end
        end
      end
    end
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #2000000;
    $display("diff_drive_pose_step_tb: errors");
    $finish;
  end

endmodule

>>> diff_drive_pose_step.f
rtl/core/ddps_pkg.sv
rtl/core/diff_drive_pose_step.sv
test/diff_drive_pose_step_tb.sv
